[hw/rtl/kbg_pkg.sv]
// Shared types and codes for the keyed batch grouper.
package kbg_pkg;

   localparam logic [1:0] OP_ADD     = 2'd0;
   localparam logic [1:0] OP_TICK    = 2'd1;
   localparam logic [1:0] OP_COLLECT = 2'd2;

   localparam logic [1:0] MODE_AGE           = 2'd0;
   localparam logic [1:0] MODE_SIZE_AND_AGE  = 2'd1;
   localparam logic [1:0] MODE_SIZE          = 2'd2;
   localparam logic [1:0] MODE_SIZE_THEN_AGE = 2'd3;

   localparam logic [1:0] KIND_ACK     = 2'd0;
   localparam logic [1:0] KIND_ITEM    = 2'd1;
   localparam logic [1:0] KIND_NOTHING = 2'd2;

   localparam logic [1:0] STAT_APPENDED   = 2'd0;
   localparam logic [1:0] STAT_OPENED     = 2'd1;
   localparam logic [1:0] STAT_GROUP_FULL = 2'd2;
   localparam logic [1:0] STAT_TABLE_FULL = 2'd3;

   localparam logic [1:0] CSR_MODE      = 2'd0;
   localparam logic [1:0] CSR_THRESHOLD = 2'd1;
   localparam logic [1:0] CSR_AGE_LIMIT = 2'd2;

   localparam logic [1:0]  RESET_MODE      = MODE_SIZE;
   localparam logic [3:0]  RESET_THRESHOLD = 4'd4;
   localparam logic [15:0] RESET_AGE_LIMIT = 16'd10;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_SCAN,
      ST_NONE,
      ST_READ,
      ST_EMIT,
      ST_COMPACT
   } state_type;

   typedef struct packed {
      logic accept;
      logic add_commit;
      logic load_none;
      logic load_item;
      logic compact;
   } ctl_cmd_type;

   typedef struct packed {
      logic [1:0] req_op;
      logic       out_free;
      logic       rel_any;
      logic       item_last;
      logic       rest_empty;
      logic       gone_any;
   } ctl_stat_type;

endpackage

[hw/rtl/keyed_batch_grouper.sv]
// Sequence: an accepted add goes to an add state, which loads its acknowledge into the result
// register and returns to idle for the next item; a tick is done in idle. A collect passes a
// scan state, a read and an emit state per released item (the item memory has a registered
// read port) or a nothing state if none is found, then compaction of one group per step.
// One item is worked on at a time, and a result waiting for rsp_tready stalls the work.
// Reset is synchronous and active high; it empties the table, zeroes time and loads mode 2.
module keyed_batch_grouper import kbg_pkg::*; #(
   parameter int MAX_GROUPS      = 8,
   parameter int ITEMS_PER_GROUP = 8
) (
   input  logic        clock,
   input  logic        reset,
   // Input item: operation [1:0], group_key [33:2], item_handle [65:34], zero fill above.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,
   // Result item: add_status [1:0], out_key [33:2], out_item [65:34], group_end [66].
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,
   // Result kind: result_kind [1:0].
   output logic [1:0]  rsp_tuser,
   // High on the final result caused by one input item.
   output logic        rsp_tlast,
   // Configuration writes: index 0 mode, 1 size threshold, 2 age limit.
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   ctl_cmd_type  cmd;
   ctl_stat_type stat;
   logic [1:0]   status;
   logic [31:0]  key;
   logic [31:0]  item;
   logic         gend;

   // The controller decides the order of work; it never touches payload.
   kbg_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the group table, the item memory and the result register.
   kbg_datapath #(
      .MAX_GROUPS     (MAX_GROUPS),
      .ITEMS_PER_GROUP(ITEMS_PER_GROUP)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_op    (req_tdata[1:0]),
      .req_key   (req_tdata[33:2]),
      .req_item  (req_tdata[65:34]),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_tready(rsp_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_kind  (rsp_tuser),
      .rsp_status(status),
      .rsp_key   (key),
      .rsp_item  (item),
      .rsp_gend  (gend),
      .rsp_last  (rsp_tlast)
   );

   // The upper bits of the result word are zero fill.
   assign rsp_tdata = {5'd0, gend, item, key, status};

endmodule

[hw/rtl/kbg_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module kbg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/kbg_datapath.sv]
// Datapath: group table, item memory, configuration and the result register.
module kbg_datapath import kbg_pkg::*; #(
   parameter int MAX_GROUPS      = 8,
   parameter int ITEMS_PER_GROUP = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic [1:0]   req_op,
   input  logic [31:0]  req_key,
   input  logic [31:0]  req_item,
   input  logic         csr_we,
   input  logic [1:0]   csr_addr,
   input  logic [15:0]  csr_wdata,
   input  ctl_cmd_type  cmd,
   output ctl_stat_type stat,
   input  logic         rsp_tready,
   output logic         rsp_tvalid,
   output logic [1:0]   rsp_kind,
   output logic [1:0]   rsp_status,
   output logic [31:0]  rsp_key,
   output logic [31:0]  rsp_item,
   output logic         rsp_gend,
   output logic         rsp_last
);

   localparam int GW    = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
   localparam int NW    = $clog2(MAX_GROUPS + 1);
   localparam int CW    = $clog2(ITEMS_PER_GROUP + 1);
   localparam int IW    = (ITEMS_PER_GROUP > 1) ? $clog2(ITEMS_PER_GROUP) : 1;
   localparam int DEPTH = MAX_GROUPS * ITEMS_PER_GROUP;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [1:0]            mode_ff;
   logic [3:0]            thr_ff;
   logic [15:0]           age_ff;
   logic [31:0]           tick_ff;
   logic [NW-1:0]         in_use_ff;
   logic [31:0]           key_ff  [MAX_GROUPS];
   logic [31:0]           open_ff [MAX_GROUPS];
   logic [CW-1:0]         cnt_ff  [MAX_GROUPS];
   logic [GW-1:0]         row_ff  [MAX_GROUPS];
   logic [MAX_GROUPS-1:0] gone_ff;
   logic [MAX_GROUPS-1:0] rem1_ff;
   logic [MAX_GROUPS-1:0] rem2_ff;
   logic [IW-1:0]         idx_ff;
   logic [31:0]           lat_key_ff;
   logic [31:0]           lat_item_ff;
   logic                  ov_ff;
   logic [1:0]            okind_ff;
   logic [1:0]            ostat_ff;
   logic [31:0]           okey_ff;
   logic [31:0]           oitem_ff;
   logic                  ogend_ff;
   logic                  olast_ff;

   logic [MAX_GROUPS-1:0] live;
   logic [MAX_GROUPS-1:0] size_ok;
   logic [MAX_GROUPS-1:0] age_ok;
   logic [MAX_GROUPS-1:0] rel1;
   logic [MAX_GROUPS-1:0] rel2;
   logic [MAX_GROUPS-1:0] used_rows;
   logic [MAX_GROUPS-1:0] sel;
   logic [MAX_GROUPS-1:0] cur_oh;
   logic                  found;
   logic [GW-1:0]         mg;
   logic [GW-1:0]         free_row;
   logic [GW-1:0]         cur;
   logic [GW-1:0]         cj;
   logic                  grp_full;
   logic                  tbl_full;
   logic [1:0]            add_stat;
   logic                  item_last;
   logic                  out_free;
   logic                  wr_en;
   logic [GW-1:0]         wr_row;
   logic [CW-1:0]         wr_idx;
   logic [AW-1:0]         wr_addr;
   logic [AW-1:0]         rd_addr;
   logic [31:0]           rd_data;

   always_comb begin
      found    = 1'b0;
      mg       = '0;
      free_row = '0;
      cur      = '0;
      cj       = '0;
      used_rows = '0;
      rel1     = '0;
      rel2     = '0;
      for (int g = 0; g < MAX_GROUPS; g++) begin
         live[g]    = (NW'(g) < in_use_ff);
         size_ok[g] = ({{(8-CW){1'b0}}, cnt_ff[g]} >= {4'd0, thr_ff});
         age_ok[g]  = ((tick_ff - open_ff[g]) >= {16'd0, age_ff});
         if (live[g]) begin
            used_rows[row_ff[g]] = 1'b1;
         end
      end
      for (int g = MAX_GROUPS - 1; g >= 0; g--) begin
         if (live[g] && key_ff[g] == lat_key_ff) begin
            found = 1'b1;
            mg    = GW'(g);
         end
         if (!used_rows[g]) begin
            free_row = GW'(g);
         end
         if (gone_ff[g]) begin
            cj = GW'(g);
         end
      end
      unique case (mode_ff)
         MODE_AGE:          rel1 = age_ok & live;
         MODE_SIZE_AND_AGE: rel1 = size_ok & age_ok & live;
         MODE_SIZE:         rel1 = size_ok & live;
         MODE_SIZE_THEN_AGE: begin
            rel1 = size_ok & live;
            rel2 = age_ok & ~size_ok & live;
         end
         default:           rel1 = '0;
      endcase
      sel = (rem1_ff != '0) ? rem1_ff : rem2_ff;
      for (int g = MAX_GROUPS - 1; g >= 0; g--) begin
         if (sel[g]) begin
            cur = GW'(g);
         end
      end
      cur_oh = '0;
      cur_oh[cur] = 1'b1;
   end

   assign grp_full  = found && (cnt_ff[mg] == CW'(ITEMS_PER_GROUP));
   assign tbl_full  = !found && (in_use_ff == NW'(MAX_GROUPS));
   assign add_stat  = found ? (grp_full ? STAT_GROUP_FULL : STAT_APPENDED)
                            : (tbl_full ? STAT_TABLE_FULL : STAT_OPENED);
   assign item_last = ((CW'(idx_ff) + CW'(1)) == cnt_ff[cur]);
   assign out_free  = !ov_ff || rsp_tready;

   assign wr_en   = cmd.add_commit && !grp_full && !tbl_full;
   assign wr_row  = found ? row_ff[mg] : free_row;
   assign wr_idx  = found ? cnt_ff[mg] : '0;
   assign wr_addr = AW'(wr_row) * AW'(ITEMS_PER_GROUP) + AW'(wr_idx);
   assign rd_addr = AW'(row_ff[cur]) * AW'(ITEMS_PER_GROUP) + AW'(idx_ff);

   kbg_ram #(
      .WIDTH(32),
      .DEPTH(DEPTH)
   ) u_items (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(lat_item_ff),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= RESET_MODE;
         thr_ff    <= RESET_THRESHOLD;
         age_ff    <= RESET_AGE_LIMIT;
         tick_ff   <= '0;
         in_use_ff <= '0;
         gone_ff   <= '0;
         rem1_ff   <= '0;
         rem2_ff   <= '0;
         idx_ff    <= '0;
         ov_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               CSR_MODE:      mode_ff <= csr_wdata[1:0];
               CSR_THRESHOLD: thr_ff  <= csr_wdata[3:0];
               CSR_AGE_LIMIT: age_ff  <= csr_wdata;
               default:       ;
            endcase
         end
         // A new result loads the register; otherwise a taken result empties it.
         if (cmd.add_commit || cmd.load_none || cmd.load_item) begin
            ov_ff <= 1'b1;
         end else if (rsp_tready) begin
            ov_ff <= 1'b0;
         end
         if (cmd.accept) begin
            lat_key_ff  <= req_key;
            lat_item_ff <= req_item;
            if (req_op == OP_TICK) begin
               tick_ff <= tick_ff + 32'd1;
            end
            if (req_op == OP_COLLECT) begin
               rem1_ff <= rel1;
               rem2_ff <= rel2;
               gone_ff <= rel1 | rel2;
               idx_ff  <= '0;
            end
         end
         if (cmd.add_commit) begin
            okind_ff <= KIND_ACK;
            ostat_ff <= add_stat;
            okey_ff  <= lat_key_ff;
            oitem_ff <= lat_item_ff;
            ogend_ff <= 1'b0;
            olast_ff <= 1'b1;
            if (found && !grp_full) begin
               cnt_ff[mg] <= cnt_ff[mg] + CW'(1);
            end else if (!found && !tbl_full) begin
               key_ff[GW'(in_use_ff)]  <= lat_key_ff;
               open_ff[GW'(in_use_ff)] <= tick_ff;
               cnt_ff[GW'(in_use_ff)]  <= CW'(1);
               row_ff[GW'(in_use_ff)]  <= free_row;
               in_use_ff <= in_use_ff + NW'(1);
            end
         end
         if (cmd.load_none) begin
            okind_ff <= KIND_NOTHING;
            ostat_ff <= STAT_APPENDED;
            okey_ff  <= '0;
            oitem_ff <= '0;
            ogend_ff <= 1'b0;
            olast_ff <= 1'b1;
         end
         if (cmd.load_item) begin
            okind_ff <= KIND_ITEM;
            ostat_ff <= STAT_APPENDED;
            okey_ff  <= key_ff[cur];
            oitem_ff <= rd_data;
            ogend_ff <= item_last;
            olast_ff <= item_last && (((rem1_ff | rem2_ff) & ~cur_oh) == '0);
            if (item_last) begin
               idx_ff <= '0;
               if (rem1_ff != '0) begin
                  rem1_ff <= rem1_ff & ~cur_oh;
               end else begin
                  rem2_ff <= rem2_ff & ~cur_oh;
               end
            end else begin
               idx_ff <= idx_ff + IW'(1);
            end
         end
         if (cmd.compact) begin
            // Drop the lowest released group and slide the rest down by one.
            for (int g = 0; g < MAX_GROUPS; g++) begin
               if (g >= int'(cj)) begin
                  if (g < MAX_GROUPS - 1) begin
                     key_ff[g]  <= key_ff[g+1];
                     open_ff[g] <= open_ff[g+1];
                     cnt_ff[g]  <= cnt_ff[g+1];
                     row_ff[g]  <= row_ff[g+1];
                     gone_ff[g] <= gone_ff[g+1];
                  end else begin
                     gone_ff[g] <= 1'b0;
                  end
               end
            end
            in_use_ff <= in_use_ff - NW'(1);
         end
      end
   end

   always_comb begin
      stat.req_op     = req_op;
      stat.out_free   = out_free;
      stat.rel_any    = (rem1_ff | rem2_ff) != '0;
      stat.item_last  = item_last;
      stat.rest_empty = ((rem1_ff | rem2_ff) & ~cur_oh) == '0;
      stat.gone_any   = gone_ff != '0;
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_kind   = okind_ff;
   assign rsp_status = ostat_ff;
   assign rsp_key    = okey_ff;
   assign rsp_item   = oitem_ff;
   assign rsp_gend   = ogend_ff;
   assign rsp_last   = olast_ff;

`ifndef SYNTHESIS
   a_in_use_bound: assert property (@(posedge clock) disable iff (reset)
      in_use_ff <= NW'(MAX_GROUPS))
      else $error("group count exceeds table size");
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.add_commit || cmd.load_item || cmd.load_none) |-> out_free)
      else $error("result register overwritten");
   a_passes_disjoint: assert property (@(posedge clock) disable iff (reset)
      (rem1_ff & rem2_ff) == '0)
      else $error("group scheduled in both passes");
   a_item_pending: assert property (@(posedge clock) disable iff (reset)
      cmd.load_item |-> ((rem1_ff | rem2_ff) != '0))
      else $error("item emitted with no group pending");
`endif

endmodule

[hw/rtl/kbg_controller.sv]
// Controller state machine that sequences adds, collects and compaction.
module kbg_controller import kbg_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  ctl_stat_type stat,
   output ctl_cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               unique case (stat.req_op)
                  OP_ADD:     state_in = ST_ADD;
                  OP_COLLECT: state_in = ST_SCAN;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_ADD: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: state_in = stat.rel_any ? ST_READ : ST_NONE;
         ST_NONE: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: state_in = ST_EMIT;
         ST_EMIT: begin
            if (stat.out_free) begin
               state_in = (stat.item_last && stat.rest_empty) ? ST_COMPACT : ST_READ;
            end
         end
         ST_COMPACT: begin
            if (!stat.gone_any) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         ST_ADD:     cmd.add_commit = stat.out_free;
         ST_NONE:    cmd.load_none  = stat.out_free;
         ST_EMIT:    cmd.load_item  = stat.out_free;
         ST_COMPACT: cmd.compact    = stat.gone_any;
         default:    ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $countones(cmd) <= 1)
      else $error("more than one datapath command at once");
   a_emit_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> ($past(state_ff) == ST_READ || $past(state_ff) == ST_EMIT))
      else $error("emit without a memory read cycle");
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> (state_ff != ST_EMIT && state_ff != ST_COMPACT))
      else $error("bad state after accept");
`endif

endmodule
